>>> src/squared_distance_transform_line_defines.svh
//------------------------------------------------------------------------------
// squared_distance_transform_line_defines
// Assertion macros shared by the distance transform modules.
//------------------------------------------------------------------------------
`ifndef SQUARED_DISTANCE_TRANSFORM_LINE_DEFINES_SVH
`define SQUARED_DISTANCE_TRANSFORM_LINE_DEFINES_SVH

// A condition that implies another in the same cycle.
`define SDT_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// A condition that implies another in the next cycle.
`define SDT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> src/sdt_pkg.sv
//------------------------------------------------------------------------------
// sdt_pkg
// Types, constants and helpers of the line distance transform.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package sdt_pkg;

  localparam int LINE_LEN   = 64;
  localparam int VALUE_BITS = 16;
  localparam int POS_BITS   = $clog2(LINE_LEN);
  localparam int CNT_BITS   = $clog2(LINE_LEN + 1);
  // numerator spans +-(inf + pos^2), denominator spans +-2*LINE_LEN
  localparam int NUM_BITS   = VALUE_BITS + 2 * POS_BITS + 2;
  localparam int DEN_BITS   = POS_BITS + 3;
  localparam int PROD_BITS  = NUM_BITS + DEN_BITS;

  localparam logic [VALUE_BITS-1:0] VAL_INF = '1;

  typedef enum logic [1:0] {
    BK_NEG_INF = 2'd0,
    BK_FINITE  = 2'd1,
    BK_POS_INF = 2'd2
  } bound_kind_t;

  typedef struct packed {
    bound_kind_t               kind;
    logic signed [NUM_BITS-1:0] num;
    logic signed [DEN_BITS-1:0] den;
  } bound_t;

  typedef struct packed {
    logic [15:0] sample_value;
    logic        occupied;
    logic        last_in;
  } sdt_in_t;

  typedef struct packed {
    logic [5:0]  position;
    logic [15:0] squared_distance;
    logic        last_out;
  } sdt_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_B_RD,
    ST_B_VAL,
    ST_B_CROSS,
    ST_B_CMP,
    ST_B_PUSH,
    ST_E_RD,
    ST_E_CHK,
    ST_E_VAL,
    ST_E_OUT
  } sdt_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // store sample
    logic b_init;     // envelope start
    logic b_rd;       // read line values of q and vertex[k], bound[k]
    logic b_cross;    // latch crossing point
    logic b_pop;      // k--
    logic b_push;     // k++, write vertex and bound
    logic e_init;     // emit start
    logic e_rd;       // read bound[k+1]
    logic e_adv;      // k++
    logic e_vrd;      // read vertex value
    logic e_emit;     // produce result, q++
  } sdt_cmd_t;

  typedef struct packed {
    logic line_done;  // last sample loaded
    logic q_end;      // q reached n-1
    logic k_zero;
    logic pop_ok;     // s <= bound[k]
    logic k_at_top;
    logic below;      // bound[k+1] below q
  } sdt_status_t;

  function automatic bound_t cross_point(
    input logic [POS_BITS-1:0]   q,
    input logic [VALUE_BITS-1:0] fq,
    input logic [POS_BITS-1:0]   v,
    input logic [VALUE_BITS-1:0] fv
  );
    bound_t b;
    logic qi;
    logic vi;
    qi = (fq == VAL_INF);
    vi = (fv == VAL_INF);
    b.num = '0;
    b.den = DEN_BITS'(1);
    if (qi && vi) begin
      b.kind = BK_FINITE;
    end else if (qi) begin
      b.kind = BK_POS_INF;
    end else if (vi) begin
      b.kind = BK_NEG_INF;
    end else begin
      b.kind = BK_FINITE;
      // two's complement wrap at NUM_BITS gives the signed difference
      b.num = NUM_BITS'(fq) + NUM_BITS'(q) * NUM_BITS'(q)
            - NUM_BITS'(fv) - NUM_BITS'(v) * NUM_BITS'(v);
      b.den = DEN_BITS'({3'b000, q} - {3'b000, v}) <<< 1;
    end
    return b;
  endfunction

endpackage

>>> src/sdt_ram.sv
//------------------------------------------------------------------------------
// sdt_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module sdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/sdt_datapath.sv
//------------------------------------------------------------------------------
// sdt_datapath
// Line store, envelope store, crossing arithmetic and result generation.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "squared_distance_transform_line_defines.svh"
module sdt_datapath
  import sdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        occupancy_mode,
  input  sdt_in_t     req,
  input  sdt_cmd_t    cmd,
  output sdt_status_t status,
  output logic        result_valid,
  output sdt_out_t    result
);
  localparam int BND_BITS = $bits(bound_t);
  localparam int BND_DEPTH = LINE_LEN + 1;
  localparam int BA_BITS = $clog2(BND_DEPTH);

  logic [CNT_BITS-1:0] line_count;
  logic [CNT_BITS-1:0] n_len;
  logic [POS_BITS-1:0] q;
  logic [POS_BITS-1:0] k;
  logic [POS_BITS-1:0] top;
  logic                last_seen;
  logic                line_end;
  logic                k_zero_r;

  // Two value memories so that f(q) and f(v) are read together.
  logic                  val_we;
  logic [POS_BITS-1:0]   val_wa;
  logic [VALUE_BITS-1:0] val_wd;
  logic [POS_BITS-1:0]   va_ra;
  logic [POS_BITS-1:0]   vb_ra;
  logic [VALUE_BITS-1:0] va_rd;
  logic [VALUE_BITS-1:0] vb_rd;

  logic                vtx_we;
  logic [POS_BITS-1:0] vtx_wa;
  logic [POS_BITS-1:0] vtx_wd;
  logic [POS_BITS-1:0] vtx_ra;
  logic [POS_BITS-1:0] vtx_rd;

  logic                bnd_we;
  logic [BA_BITS-1:0]  bnd_wa;
  bound_t              bnd_wd;
  logic [BA_BITS-1:0]  bnd_ra;
  logic [BND_BITS-1:0] bnd_rd;
  bound_t              bnd_q;

  bound_t              s;
  logic [POS_BITS-1:0] v_hold;
  logic signed [PROD_BITS-1:0] prod_a;
  logic signed [PROD_BITS-1:0] prod_b;
  logic [VALUE_BITS-1:0] sample;
  logic signed [POS_BITS:0] dq;
  logic [VALUE_BITS+1:0] dsum;

  assign bnd_q = bound_t'(bnd_rd);

  assign sample = occupancy_mode ? (req.occupied ? '0 : VAL_INF) : req.sample_value;

  assign line_end = req.last_in || line_count == CNT_BITS'(LINE_LEN - 1);

  always_comb begin
    val_we = cmd.load;
    val_wa = line_count[POS_BITS-1:0];
    val_wd = sample;
  end

  sdt_ram #(.WIDTH(VALUE_BITS), .DEPTH(LINE_LEN)) u_val_a (
    .clk, .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(va_ra), .rdata(va_rd));
  sdt_ram #(.WIDTH(VALUE_BITS), .DEPTH(LINE_LEN)) u_val_b (
    .clk, .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(vb_ra), .rdata(vb_rd));
  sdt_ram #(.WIDTH(POS_BITS), .DEPTH(LINE_LEN)) u_vtx (
    .clk, .we(vtx_we), .waddr(vtx_wa), .wdata(vtx_wd), .raddr(vtx_ra), .rdata(vtx_rd));
  sdt_ram #(.WIDTH(BND_BITS), .DEPTH(BND_DEPTH)) u_bnd (
    .clk, .we(bnd_we), .waddr(bnd_wa), .wdata(bnd_wd), .raddr(bnd_ra), .rdata(bnd_rd));

  // Vertex memory: slot 0 always holds vertex 0, written at envelope start.
  always_comb begin
    vtx_we = cmd.b_init || cmd.b_push;
    vtx_wa = cmd.b_init ? '0 : POS_BITS'(k + 1'b1);
    vtx_wd = cmd.b_init ? '0 : q;
    bnd_we = cmd.b_push;
    bnd_wa = BA_BITS'(k) + BA_BITS'(1);
    bnd_wd = s;
    vtx_ra = k;
    bnd_ra = cmd.e_rd ? BA_BITS'(k) + BA_BITS'(1) : BA_BITS'(k);
    va_ra  = q;
    // f(v) is addressed by the registered vertex read data
    vb_ra  = vtx_rd;
  end

  // Compare s <= bound[k] exactly: cross-multiply fractions.
  assign prod_a = PROD_BITS'(s.num) * PROD_BITS'(bnd_q.den);
  assign prod_b = PROD_BITS'(bnd_q.num) * PROD_BITS'(s.den);

  always_comb begin
    if (s.kind != bnd_q.kind) begin
      status.pop_ok = (s.kind < bnd_q.kind);
    end else if (s.kind != BK_FINITE) begin
      status.pop_ok = 1'b1;
    end else begin
      status.pop_ok = (prod_a <= prod_b);
    end
    status.line_done = last_seen;
    status.q_end     = ({1'b0, q} == CNT_BITS'(n_len - 1'b1));
    status.k_zero    = k_zero_r;
    status.k_at_top  = (k == top);
    if (bnd_q.kind == BK_NEG_INF) begin
      status.below = 1'b1;
    end else if (bnd_q.kind == BK_POS_INF) begin
      status.below = 1'b0;
    end else begin
      status.below = bnd_q.num <
                     (PROD_BITS'($signed({1'b0, q})) * PROD_BITS'(bnd_q.den));
    end
  end

  assign dq   = $signed({1'b0, q}) - $signed({1'b0, v_hold});
  assign dsum = (VALUE_BITS+2)'(dq * dq) + (VALUE_BITS+2)'(vb_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      last_seen    <= 1'b0;
      result_valid <= 1'b0;
      k            <= '0;
      q            <= '0;
      top          <= '0;
      n_len        <= '0;
      k_zero_r     <= 1'b1;
    end else begin
      result_valid <= cmd.e_emit;
      last_seen    <= cmd.load && line_end;
      if (cmd.load) begin
        if (line_end) begin
          n_len      <= line_count + 1'b1;
          line_count <= '0;
        end else begin
          line_count <= line_count + 1'b1;
        end
      end
      // emit start wins over the last push or the envelope start
      if (cmd.e_init) begin
        k <= '0;
        q <= '0;
      end else if (cmd.b_init) begin
        k <= '0;
        q <= POS_BITS'(1);
      end else if (cmd.b_pop) begin
        k <= k - 1'b1;
      end else if (cmd.b_push) begin
        k <= k + 1'b1;
        q <= q + 1'b1;
      end else if (cmd.e_adv) begin
        k <= k + 1'b1;
      end else if (cmd.e_emit) begin
        // park q at zero so the next line starts from position 0
        q <= status.q_end ? '0 : q + 1'b1;
      end
      if (cmd.b_init) begin
        k_zero_r <= 1'b1;
        top      <= '0;
      end else if (cmd.b_pop) begin
        k_zero_r <= (k == POS_BITS'(1));
      end else if (cmd.b_push) begin
        k_zero_r <= 1'b0;
        top      <= k + 1'b1;
      end
      if (cmd.b_cross) begin
        s <= cross_point(q, va_rd, vtx_rd, vb_rd);
      end
      if (cmd.e_vrd) begin
        v_hold <= vtx_rd;
      end
      if (cmd.e_emit) begin
        result.position <= 6'(q);
        result.last_out <= status.q_end;
        if (vb_rd == VAL_INF || dsum > (VALUE_BITS+2)'(VAL_INF)) begin
          result.squared_distance <= 16'(VAL_INF);
        end else begin
          result.squared_distance <= 16'(dsum);
        end
      end
    end
  end

  `SDT_ASSERT_IMPL(a_pop_nonzero, clk, rst, cmd.b_pop, !k_zero_r, "pop with empty envelope")
  `SDT_ASSERT_NEXT(a_emit_strobe, clk, rst, cmd.e_emit, result_valid, "emit lost")
  `SDT_ASSERT_IMPL(a_adv_bound, clk, rst, cmd.e_adv, k != top, "advance past envelope top")
endmodule

>>> src/sdt_ctrl.sv
//------------------------------------------------------------------------------
// sdt_ctrl
// Sequencer for load, envelope build and emit phases.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "squared_distance_transform_line_defines.svh"
module sdt_ctrl
  import sdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  sdt_status_t status,
  output sdt_cmd_t    cmd
);
  sdt_state_t state;
  sdt_state_t state_next;
  logic       q_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // In build, q_end flags q == n-1 which is the last vertex to push.
  assign q_last = status.q_end;

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_LOAD: begin
        busy = 1'b0;
        if (status.line_done) begin
          busy = 1'b1;
          cmd.b_init = 1'b1;
          if (status.q_end) begin
            // single-sample line: vertex 0 only
            state_next = ST_E_RD;
          end else begin
            state_next = ST_B_RD;
          end
        end else if (start) begin
          cmd.load = 1'b1;
        end
      end
      ST_B_RD: begin
        cmd.b_rd = 1'b1;
        state_next = ST_B_VAL;
      end
      ST_B_VAL: begin
        // hold while f(v) follows the vertex read
        state_next = ST_B_CROSS;
      end
      ST_B_CROSS: begin
        cmd.b_cross = 1'b1;
        state_next = ST_B_CMP;
      end
      ST_B_CMP: begin
        if (!status.k_zero && status.pop_ok) begin
          cmd.b_pop = 1'b1;
          state_next = ST_B_RD;
        end else begin
          state_next = ST_B_PUSH;
        end
      end
      ST_B_PUSH: begin
        cmd.b_push = 1'b1;
        if (q_last) begin
          state_next = ST_E_RD;
        end else begin
          state_next = ST_B_RD;
        end
      end
      ST_E_RD: begin
        cmd.e_rd = 1'b1;
        state_next = ST_E_CHK;
      end
      ST_E_CHK: begin
        if (!status.k_at_top && status.below) begin
          cmd.e_adv = 1'b1;
          cmd.e_rd  = 1'b1;
          state_next = ST_E_RD;
        end else begin
          state_next = ST_E_VAL;
        end
      end
      ST_E_VAL: begin
        cmd.e_vrd = 1'b1;
        state_next = ST_E_OUT;
      end
      ST_E_OUT: begin
        cmd.e_emit = 1'b1;
        if (status.q_end) begin
          state_next = ST_LOAD;
        end else begin
          state_next = ST_E_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  `SDT_ASSERT_IMPL(a_load_idle, clk, rst, cmd.load, state == ST_LOAD, "load outside idle")
  `SDT_ASSERT_IMPL(a_busy_load, clk, rst, start && !busy, cmd.load, "request dropped")
  `SDT_ASSERT_NEXT(a_push_next, clk, rst, cmd.b_push && !q_last, state == ST_B_RD, "push stuck")
endmodule

>>> src/sdt_emit_init.sv
//------------------------------------------------------------------------------
// sdt_emit_init
// Emit-phase start detect: pulses when the build phase hands over.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module sdt_emit_init
  import sdt_pkg::*;
(
  input  sdt_cmd_t cmd_in,
  input  logic     single,
  output sdt_cmd_t cmd_out
);
  // Reset k and q on the last push or on the start of a single-sample line.
  always_comb begin
    cmd_out = cmd_in;
    if ((cmd_in.b_push || cmd_in.b_init) && single) begin
      cmd_out.e_init = 1'b1;
    end
  end
endmodule

>>> src/squared_distance_transform_line.sv
//------------------------------------------------------------------------------
// squared_distance_transform_line
// One 1D pass of the lower-envelope squared distance transform.
//------------------------------------------------------------------------------
// Samples load at one request per cycle while busy is low; the build starts in the
// cycle after the last request. Each candidate is read, waits for f(v), is crossed
// and compared, then popped or pushed. Each result checks bound[k+1] per advance,
// then reads its vertex value and is output, through registered memories. busy is
// high from the cycle after the last request until the last result is strobed;
// results cannot be stalled. Reset clears the line count and occupancy_mode.
`timescale 1ns / 1ps
module squared_distance_transform_line
  import sdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  sdt_in_t  req,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output logic     result_valid,
  output sdt_out_t result
);
  logic        occupancy_mode;
  sdt_cmd_t    cmd_raw;
  sdt_cmd_t    cmd;
  sdt_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy_mode <= 1'b0;
    end else if (cfg_we) begin
      occupancy_mode <= cfg_wdata;
    end
  end

  sdt_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .status, .cmd(cmd_raw));

  sdt_emit_init u_emit_init (
    .cmd_in(cmd_raw), .single(status.q_end), .cmd_out(cmd));

  sdt_datapath u_dp (
    .clk, .rst, .occupancy_mode, .req, .cmd, .status, .result_valid, .result);
endmodule

>>> tb/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Line distance transform testbench: random lines are sent as requests in
// value and occupancy mode, the lower envelope is computed alongside and each
// strobed result is checked in order against it.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import sdt_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  sdt_in_t  req;
  logic     cfg_we;
  logic     cfg_wdata;
  logic     result_valid;
  sdt_out_t result;

  squared_distance_transform_line uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .result_valid(result_valid), .result(result)
  );

  typedef struct {
    longint kind;
    longint num;
    longint den;
  } cut_t;

  localparam longint INF = 65535;
  localparam longint KIND_NEG = 0;
  localparam longint KIND_FIN = 1;
  localparam longint KIND_POS = 2;

  sdt_in_t  pending_q[$];
  sdt_out_t dist_q[$];
  logic     occ_mode;
  longint   line_buf[LINE_LEN];
  int       line_n;
  bit       failed;
  bit       no_idle;
  int       gap_left;
  longint   cycles;
  int       hold_at;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic cut_t crossing(int q, int v);
    cut_t b;
    b.num = 0;
    b.den = 1;
    if (line_buf[q] == INF && line_buf[v] == INF) b.kind = KIND_FIN;
    else if (line_buf[q] == INF) b.kind = KIND_POS;
    else if (line_buf[v] == INF) b.kind = KIND_NEG;
    else begin
      b.kind = KIND_FIN;
      b.num = line_buf[q] + q * q - line_buf[v] - v * v;
      b.den = 2 * (q - v);
    end
    return b;
  endfunction

  function automatic bit cut_le(cut_t a, cut_t b);
    if (a.kind != b.kind) return a.kind < b.kind;
    if (a.kind != KIND_FIN) return 1;
    return a.num * b.den <= b.num * a.den;
  endfunction

  // Fold the line into its parabola envelope and queue every distance.
  task automatic solve_line(int n);
    int   verts[LINE_LEN];
    cut_t cuts[LINE_LEN + 1];
    cut_t s;
    int   k, top, v;
    longint d;
    sdt_out_t o;
    k = 0;
    verts[0] = 0;
    for (int q = 1; q < n; q++) begin
      s = crossing(q, verts[k]);
      while (k > 0 && cut_le(s, cuts[k])) begin
        k--;
        s = crossing(q, verts[k]);
      end
      k++;
      verts[k] = q;
      cuts[k] = s;
    end
    top = k;
    k = 0;
    for (int q = 0; q < n; q++) begin
      while (k < top && (cuts[k+1].kind == KIND_NEG ||
             (cuts[k+1].kind == KIND_FIN && cuts[k+1].num < q * cuts[k+1].den)))
        k++;
      v = verts[k];
      if (line_buf[v] == INF) d = INF;
      else begin
        d = (q - v) * (q - v) + line_buf[v];
        if (d > INF) d = INF;
      end
      o.position = q[5:0];
      o.squared_distance = d[15:0];
      o.last_out = (q == n - 1);
      dist_q.push_back(o);
    end
  endtask

  task automatic accept_sample(sdt_in_t it);
    if (line_n >= LINE_LEN) line_n = 0;
    line_buf[line_n] = occ_mode ? (it.occupied ? 0 : INF) : longint'(it.sample_value);
    line_n++;
    if (it.last_in || line_n >= LINE_LEN) begin
      solve_line(line_n);
      line_n = 0;
    end
  endtask

  // Driver: present requests, idle in bursts, hold off when asked.
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else begin
      if (start && !busy) begin
        accept_sample(req);
        void'(pending_q.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 0;
      end else if (pending_q.size() > ((start && !busy) ? 0 : 0) &&
                   !(hold_at >= 0 && pending_q.size() == hold_at &&
                     dist_q.size() != 0)) begin
        if (!no_idle && !(start && busy) && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(1, 17) - 1;
          start <= 0;
        end else begin
          start <= 1;
          req <= pending_q[0];
        end
      end else begin
        start <= 0;
      end
    end
  end

  // Monitor: check each strobed result against the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid) begin
      if (dist_q.size() == 0) begin
        $error("unexpected result at position %0d", result.position);
        failed = 1;
      end else begin
        if (result.position !== dist_q[0].position) begin
          $error("position expected %0d actual %0d", dist_q[0].position, result.position);
          failed = 1;
        end
        if (result.squared_distance !== dist_q[0].squared_distance) begin
          $error("squared_distance expected %0d actual %0d",
                 dist_q[0].squared_distance, result.squared_distance);
          failed = 1;
        end
        if (result.last_out !== dist_q[0].last_out) begin
          $error("last_out expected %0d actual %0d", dist_q[0].last_out, result.last_out);
          failed = 1;
        end
        void'(dist_q.pop_front());
      end
    end
    if (cycles > 2000000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic sdt_in_t make_sample(int kind, bit last);
    sdt_in_t it;
    it.occupied = 1'($urandom_range(0, 1));
    it.last_in = last;
    case (kind)
      0: it.sample_value = 16'hFFFF;
      1: it.sample_value = 16'h0000;
      2: it.sample_value = 16'($urandom_range(0, 200));
      default: it.sample_value = 16'($urandom);
    endcase
    return it;
  endfunction

  task automatic add_line(int n, int bias);
    for (int i = 0; i < n; i++)
      pending_q.push_back(make_sample((bias >= 0) ? bias : $urandom_range(0, 4),
                                      i == n - 1));
  endtask

  // Let the block drain completely before touching the register.
  task automatic drain_and_set(bit mode);
    while (pending_q.size() != 0 || dist_q.size() != 0 || start) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wdata <= mode;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    occ_mode = mode;
  endtask

  initial begin
    rst = 1;
    start = 0;
    req = '0;
    cfg_we = 0;
    cfg_wdata = 0;
    occ_mode = 0;
    line_n = 0;
    failed = 0;
    no_idle = 0;
    gap_left = 0;
    cycles = 0;
    hold_at = -1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    drain_and_set(0);
    // single sample lines, all infinite, all zero, extremes, overlong line
    add_line(1, 3);
    add_line(1, 0);
    add_line(3, 0);
    add_line(3, 1);
    pending_q.push_back('{sample_value: 16'hFFFF, occupied: 0, last_in: 0});
    pending_q.push_back('{sample_value: 16'h0000, occupied: 1, last_in: 0});
    pending_q.push_back('{sample_value: 16'hFFFE, occupied: 0, last_in: 1});
    add_line(4, 2);
    for (int i = 0; i < 70; i++)
      pending_q.push_back(make_sample($urandom_range(0, 4), i == 69));
    hold_at = pending_q.size() - 5;
    drain_and_set(1);
    hold_at = -1;
    for (int i = 0; i < 4; i++) add_line($urandom_range(1, 12), -1);
    drain_and_set(0);
    for (int i = 0; i < 4; i++) add_line($urandom_range(1, 12), -1);
    add_line(64, -1);
    drain_and_set(1);
    for (int i = 0; i < 2; i++) add_line($urandom_range(1, 10), -1);
    drain_and_set(0);
    no_idle = 1;
    for (int i = 0; i < 3; i++) add_line($urandom_range(1, 10), -1);
    while (pending_q.size() != 0 || dist_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
